// ===== rtl/core/aes_pkg.sv =====
package aes_pkg;

	typedef struct packed {
		logic        mode;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} aes_out_t;

	// register indexes of the configuration port
	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;

	localparam logic       MODE_ENCRYPT = 1'b0;
	localparam logic       MODE_DECRYPT = 1'b1;

	localparam logic [7:0] XT_POLY = 8'h1b;

	localparam logic [7:0] FWD_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// commands from the controller to the datapath
	typedef struct packed {
		logic       load;
		logic       round;
		logic       last;
		logic [3:0] rnd;
		logic       exp_step;
		logic [3:0] exp_idx;
	} aes_cmd_t;

	typedef struct packed {
		logic key_written;
	} aes_status_t;

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? XT_POLY : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] i);
		logic [7:0] rc;
		case (i)
			4'd1:    rc = 8'h01;
			4'd2:    rc = 8'h02;
			4'd3:    rc = 8'h04;
			4'd4:    rc = 8'h08;
			4'd5:    rc = 8'h10;
			4'd6:    rc = 8'h20;
			4'd7:    rc = 8'h40;
			4'd8:    rc = 8'h80;
			4'd9:    rc = 8'h1b;
			4'd10:   rc = 8'h36;
			default: rc = 8'h00;
		endcase
		return rc;
	endfunction

	// byte k of the block sits at bits 127-8k down
	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		int src;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv) begin
					src = ((c + 4 - r) % 4) * 4 + r;
					o[127 - 8 * (c * 4 + r) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
				end else begin
					src = ((c + r) % 4) * 4 + r;
					o[127 - 8 * (c * 4 + r) -: 8] = FWD_SBOX[s[127 - 8 * src -: 8]];
				end
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]  = s[127 - 8 * (c * 4 + k) -: 8];
				x2[k] = xt(a[k]);
				x4[k] = xt(x2[k]);
				x8[k] = xt(x4[k]);
				m9[k] = x8[k] ^ a[k];
				mb[k] = x8[k] ^ x2[k] ^ a[k];
				md[k] = x8[k] ^ x4[k] ^ a[k];
				me[k] = x8[k] ^ x4[k] ^ x2[k];
			end
			for (int r = 0; r < 4; r++) begin
				if (inv)
					o[127 - 8 * (c * 4 + r) -: 8] = me[r] ^ mb[(r + 1) % 4]
						^ md[(r + 2) % 4] ^ m9[(r + 3) % 4];
				else
					o[127 - 8 * (c * 4 + r) -: 8] = x2[r] ^ x2[(r + 1) % 4]
						^ a[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w3;
		logic [31:0] t;
		logic [31:0] n0;
		logic [31:0] n1;
		logic [31:0] n2;
		logic [31:0] n3;
		w3 = k[31:0];
		t = {FWD_SBOX[w3[23:16]], FWD_SBOX[w3[15:8]], FWD_SBOX[w3[7:0]],
			FWD_SBOX[w3[31:24]]} ^ {rc, 24'h000000};
		n0 = k[127:96] ^ t;
		n1 = k[95:64] ^ n0;
		n2 = k[63:32] ^ n1;
		n3 = k[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

endpackage

// ===== rtl/core/aes_dpath.sv =====
module aes_dpath #(
	parameter int ROUND_KEY_WORDS = 44
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [63:0]           cfg_data,
	input  aes_pkg::aes_in_t      item,
	input  aes_pkg::aes_cmd_t     cmd,
	output aes_pkg::aes_status_t  status,
	output aes_pkg::aes_out_t     result
);

	localparam int NR = ROUND_KEY_WORDS / 4 - 1;
	localparam int NK = NR + 1;

	logic [63:0]  key_high_q;
	logic [63:0]  key_low_q;
	logic [127:0] kw_q;
	logic [127:0] rk_q [NK];
	logic [127:0] state_q;
	logic         dec_q;
	logic [3:0]   rk_idx;
	logic [127:0] rk;
	logic [127:0] blk;
	logic [127:0] kn;
	logic [127:0] ss;
	logic [127:0] nxt;
	logic         dec;

	assign status.key_written = cfg_we &&
		(cfg_index == aes_pkg::REG_KEY_HIGH || cfg_index == aes_pkg::REG_KEY_LOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == aes_pkg::REG_KEY_HIGH)
				key_high_q <= cfg_data;
			else if (cfg_index == aes_pkg::REG_KEY_LOW)
				key_low_q <= cfg_data;
		end
	end

	// key schedule, one round key per cycle
	assign kn = (cmd.exp_idx == '0) ? {key_high_q, key_low_q}
		: aes_pkg::key_next(kw_q, aes_pkg::rcon(cmd.exp_idx));

	always_ff @(posedge clk) begin
		if (cmd.exp_step) begin
			kw_q <= kn;
			rk_q[cmd.exp_idx] <= kn;
		end
	end

	assign dec = cmd.load ? (item.mode == aes_pkg::MODE_DECRYPT) : dec_q;

	always_comb begin
		if (cmd.load)
			rk_idx = dec ? 4'(NR) : 4'd0;
		else
			rk_idx = dec ? 4'(NR) - cmd.rnd : cmd.rnd;
	end

	assign rk  = rk_q[rk_idx];
	assign blk = {item.block_high, item.block_low};
	assign ss  = aes_pkg::sub_shift(state_q, dec);

	always_comb begin
		if (cmd.load)
			nxt = blk ^ rk;
		else if (dec)
			nxt = cmd.last ? (ss ^ rk) : aes_pkg::mix(ss ^ rk, 1'b1);
		else
			nxt = (cmd.last ? ss : aes_pkg::mix(ss, 1'b0)) ^ rk;
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.round)
			state_q <= nxt;
		if (cmd.load)
			dec_q <= dec;
	end

	assign result.result_high = state_q[127:64];
	assign result.result_low  = state_q[63:0];

endmodule

// ===== rtl/core/aes_ctrl.sv =====
module aes_ctrl #(
	parameter int ROUND_KEY_WORDS = 44
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  aes_pkg::aes_status_t status,
	output aes_pkg::aes_cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);

	localparam int NR = ROUND_KEY_WORDS / 4 - 1;

	typedef enum logic [1:0] {
		ST_EXPAND,
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t     state_q;
	logic [3:0] cnt_q;
	logic       done_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	assign cmd.load     = start && (state_q == ST_IDLE);
	assign cmd.round    = (state_q == ST_RUN);
	assign cmd.last     = (cnt_q == 4'(NR));
	assign cmd.rnd      = cnt_q;
	assign cmd.exp_step = (state_q == ST_EXPAND);
	assign cmd.exp_idx  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXPAND;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (status.key_written) begin
				// new key: rebuild the schedule from round zero
				state_q <= ST_EXPAND;
				cnt_q   <= '0;
			end else begin
				case (state_q)
					ST_EXPAND: begin
						if (cnt_q == 4'(NR)) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
					ST_IDLE: begin
						if (start) begin
							state_q <= ST_RUN;
							cnt_q   <= 4'd1;
						end
					end
					ST_RUN: begin
						if (cnt_q == 4'(NR)) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
							done_q  <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
					default: begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end
				endcase
			end
		end
	end

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RUN && cnt_q == 4'(NR)))
		else $error("result strobe without a final round");

	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !status.key_written) |=> (state_q == ST_RUN && cnt_q == 4'd1))
		else $error("accepted block did not start round one");

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (cnt_q >= 4'd1 && cnt_q <= 4'(NR)))
		else $error("round count out of range");

	a_key_reexpand: assert property (@(posedge clk) disable iff (!arst_n)
		status.key_written |=> (state_q == ST_EXPAND && cnt_q == 4'd0 && busy))
		else $error("key write did not restart the schedule");

endmodule

// ===== rtl/core/aes128_block_cipher_core.sv =====
// channel   | handshake          | payload
// ----------+--------------------+---------------------------------------
// input     | start & !busy      | item   (mode, block_high, block_low)
// result    | done, one cycle    | result (result_high, result_low)
// config    | cfg_we             | cfg_index, cfg_data
//
// a block runs from the accepting edge to the done cycle as one key add
// on load, then one full round per cycle through the shared round unit
// the next block may be accepted in the done cycle itself
// after reset and after every write to a key register the schedule is built,
// one round key per cycle, with busy high
// done is high for one cycle only: the receiver cannot stall
module aes128_block_cipher_core #(
	parameter int ROUND_KEY_WORDS = 44
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  aes_pkg::aes_in_t  item,
	output logic              done,
	output aes_pkg::aes_out_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data
);

	aes_pkg::aes_cmd_t    cmd;
	aes_pkg::aes_status_t status;

	aes_ctrl #(
		.ROUND_KEY_WORDS(ROUND_KEY_WORDS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	aes_dpath #(
		.ROUND_KEY_WORDS(ROUND_KEY_WORDS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		bit                   is_key;
		logic [1:0]           index;
		logic [63:0]          data;
		aes_pkg::aes_in_t     beat;
	} job_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	aes_pkg::aes_in_t  item = '0;
	logic              done;
	aes_pkg::aes_out_t result;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [63:0]       cfg_data = '0;

	job_t              pending_jobs [$];
	aes_pkg::aes_out_t expected_blocks [$];
	logic [63:0]       key_hi_model;
	logic [63:0]       key_lo_model;
	logic [31:0]       sched_words [44];
	int                errors = 0;
	int                cycles = 0;
	int                burst_left = 8;
	int                gap_left = 0;
	int                quiet_cycles = 0;

	aes128_block_cipher_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] gf_double(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? aes_pkg::XT_POLY : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = gf_double(a);
		end
		return p;
	endfunction

	function automatic void build_schedule();
		logic [31:0] t;
		logic [7:0] rc;
		rc = 8'h01;
		sched_words[0] = key_hi_model[63:32];
		sched_words[1] = key_hi_model[31:0];
		sched_words[2] = key_lo_model[63:32];
		sched_words[3] = key_lo_model[31:0];
		for (int i = 4; i < 44; i++) begin
			t = sched_words[i - 1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {aes_pkg::FWD_SBOX[t[31:24]], aes_pkg::FWD_SBOX[t[23:16]],
					aes_pkg::FWD_SBOX[t[15:8]], aes_pkg::FWD_SBOX[t[7:0]]} ^ {rc, 24'h0};
				rc = gf_double(rc);
			end
			sched_words[i] = sched_words[i - 4] ^ t;
		end
	endfunction

	// byte k of the state lives at bits 127-8k, column k/4, row k%4
	function automatic logic [127:0] subst_rows(input logic [127:0] s, input bit inv);
		logic [127:0] o;
		int src;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = inv ? ((c + 4 - r) % 4) * 4 + r : ((c + r) % 4) * 4 + r;
				o[127 - 8 * (c * 4 + r) -: 8] = inv ? aes_pkg::INV_SBOX[s[127 - 8 * src -: 8]]
					: aes_pkg::FWD_SBOX[s[127 - 8 * src -: 8]];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inv);
		logic [7:0] coef [4];
		logic [7:0] col [4];
		logic [7:0] v;
		logic [127:0] o;
		if (inv) begin
			coef[0] = 8'd14;
			coef[1] = 8'd11;
			coef[2] = 8'd13;
			coef[3] = 8'd9;
		end else begin
			coef[0] = 8'd2;
			coef[1] = 8'd3;
			coef[2] = 8'd1;
			coef[3] = 8'd1;
		end
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++)
				col[k] = s[127 - 8 * (c * 4 + k) -: 8];
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++)
					v ^= gf_mult(col[k], coef[(k + 4 - r) % 4]);
				o[127 - 8 * (c * 4 + r) -: 8] = v;
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] round_key(input int r);
		return {sched_words[4 * r], sched_words[4 * r + 1], sched_words[4 * r + 2],
			sched_words[4 * r + 3]};
	endfunction

	function automatic aes_pkg::aes_out_t cipher_block(input aes_pkg::aes_in_t b);
		logic [127:0] s;
		s = {b.block_high, b.block_low};
		if (b.mode != aes_pkg::MODE_DECRYPT) begin
			s ^= round_key(0);
			for (int r = 1; r < 10; r++)
				s = mix_columns(subst_rows(s, 0), 0) ^ round_key(r);
			s = subst_rows(s, 0) ^ round_key(10);
		end else begin
			s ^= round_key(10);
			for (int r = 9; r >= 1; r--)
				s = mix_columns(subst_rows(s, 1) ^ round_key(r), 1);
			s = subst_rows(s, 1) ^ round_key(0);
		end
		return '{result_high: s[127:64], result_low: s[63:0]};
	endfunction

	function automatic void add_block(input logic m, input logic [63:0] hi,
			input logic [63:0] lo);
		job_t j;
		j.is_key = 0;
		j.beat = '{mode: m, block_high: hi, block_low: lo};
		pending_jobs.push_back(j);
	endfunction

	function automatic void add_key_write(input logic [1:0] idx, input logic [63:0] val);
		job_t j;
		j.is_key = 1;
		j.index = idx;
		j.data = val;
		pending_jobs.push_back(j);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 64'h0;
			1: return '1;
			2: return 64'h8000_0000_0000_0001;
			default: return rand64();
		endcase
	endfunction

	// driver: one beat or one key write per cycle, in bursts, holding a beat while the core is busy
	always @(posedge clk) begin
		job_t j;
		bit taken;
		bit write_key;
		if (arst_n) begin
			taken = start && !busy;
			write_key = 1'b0;
			if (taken)
				expected_blocks.push_back(cipher_block(item));
			if (expected_blocks.size() == 0 && !start && !busy && !cfg_we)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (start && !taken) begin
				// beat still waiting for the block
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_jobs.size() == 0) begin
				start <= 1'b0;
			end else if (pending_jobs[0].is_key) begin
				start <= 1'b0;
				// keys change only once the block has drained
				if (quiet_cycles >= 16 && !taken) begin
					j = pending_jobs.pop_front();
					write_key = 1'b1;
					cfg_index <= j.index;
					cfg_data <= j.data;
					if (j.index == aes_pkg::REG_KEY_HIGH)
						key_hi_model = j.data;
					else if (j.index == aes_pkg::REG_KEY_LOW)
						key_lo_model = j.data;
					build_schedule();
					quiet_cycles = 0;
				end
			end else begin
				j = pending_jobs.pop_front();
				start <= 1'b1;
				item <= j.beat;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
				end
			end
			cfg_we <= write_key;
		end
	end

	// monitor: a result beat lasts one cycle and cannot be held off
	always @(posedge clk) begin
		aes_pkg::aes_out_t want;
		if (arst_n && done) begin
			if (expected_blocks.size() == 0) begin
				$error("unexpected result beat %h", result);
				errors++;
			end else begin
				want = expected_blocks.pop_front();
				if (result.result_high !== want.result_high) begin
					$error("result_high expected %h actual %h", want.result_high,
						result.result_high);
					errors++;
				end
				if (result.result_low !== want.result_low) begin
					$error("result_low expected %h actual %h", want.result_low,
						result.result_low);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [63:0] hi;
		logic [63:0] lo;
		key_hi_model = '0;
		key_lo_model = '0;
		build_schedule();

		// zero key straight after reset
		add_block(aes_pkg::MODE_ENCRYPT, 64'h0, 64'h0);
		add_block(aes_pkg::MODE_DECRYPT, 64'h0, 64'h0);
		add_block(aes_pkg::MODE_ENCRYPT, '1, '1);
		add_block(aes_pkg::MODE_DECRYPT, '1, '1);
		// standard test vector key and plaintext
		add_key_write(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
		add_key_write(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		add_block(aes_pkg::MODE_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		add_block(aes_pkg::MODE_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		// unknown register indexes leave the key alone
		add_key_write(2'd2, '1);
		add_key_write(2'd3, 64'h0123456789abcdef);
		add_block(aes_pkg::MODE_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		add_block(aes_pkg::MODE_DECRYPT, 64'h8000000000000000, 64'h0000000000000001);
		add_key_write(aes_pkg::REG_KEY_HIGH, '1);
		add_key_write(aes_pkg::REG_KEY_LOW, '1);
		add_block(aes_pkg::MODE_ENCRYPT, 64'h0, '1);
		add_block(aes_pkg::MODE_DECRYPT, '1, 64'h0);
		// key with zero bytes scattered through it
		add_key_write(aes_pkg::REG_KEY_HIGH, 64'h00ff0000ff000000);
		add_block(aes_pkg::MODE_ENCRYPT, 64'hfedcba9876543210, 64'h0);
		add_block(aes_pkg::MODE_DECRYPT, 64'hfedcba9876543210, 64'h0);

		for (int phase = 0; phase < 10; phase++) begin
			if (phase % 3 != 2)
				add_key_write(aes_pkg::REG_KEY_HIGH, edge_word());
			if (phase % 3 != 1)
				add_key_write(aes_pkg::REG_KEY_LOW, edge_word());
			if ($urandom_range(0, 3) == 0)
				add_key_write(2'($urandom_range(2, 3)), rand64());
			for (int n = 0; n < 90; n++) begin
				hi = ($urandom_range(0, 15) == 0) ? edge_word() : rand64();
				lo = ($urandom_range(0, 15) == 0) ? edge_word() : rand64();
				add_block(1'($urandom_range(0, 1)), hi, lo);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_jobs.size() == 0);
		@(posedge clk);
		while (start || cfg_we || expected_blocks.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
